// ===== hdl/yenc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yEnc line encoder package
// Character constants, the CRC-32 byte update and the group of encoded
// characters that one raw byte produces.
// ----------------------------------------------------------------------------
package yenc_pkg;

    localparam logic [7:0]  CHAR_OFFSET       = 8'd42;
    localparam logic [7:0]  ESC_OFFSET        = 8'd64;
    localparam logic [7:0]  CH_NUL            = 8'h00;
    localparam logic [7:0]  CH_LF             = 8'h0A;
    localparam logic [7:0]  CH_CR             = 8'h0D;
    localparam logic [7:0]  CH_EQ             = 8'h3D;
    localparam logic [7:0]  CH_DOT            = 8'h2E;
    localparam logic [7:0]  LINE_LENGTH_RESET = 8'd128;
    localparam logic [31:0] CRC_POLY          = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT          = 32'hFFFFFFFF;

    // Up to four characters, the number in use (1 to 4), the end-of-message
    // flag and the final CRC (zero unless the message ends here).
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      num;
        logic            last;
        logic [31:0]     crc;
    } group_t;

    // Reflected CRC-32 update by one byte; this is a fixed XOR network.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/yenc_enc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yEnc encoding core
// Turns one raw byte and the line state into its group of output characters,
// the next line count and the next CRC register value.
// ----------------------------------------------------------------------------
module yenc_enc_core (
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    input  wire logic [7:0]       line_count,
    input  wire logic [7:0]       line_length,
    input  wire logic [31:0]      crc_in,
    output yenc_pkg::group_t      grp,
    output logic [7:0]            count_next,
    output logic [31:0]           crc_next
);

    logic [7:0]  c;
    logic        esc;
    logic        dot;
    logic [1:0]  n_data;
    logic [9:0]  cnt_sum;
    logic        brk;
    logic [31:0] crc_upd;

    assign c   = data_byte + yenc_pkg::CHAR_OFFSET;
    assign esc = (c == yenc_pkg::CH_NUL) || (c == yenc_pkg::CH_CR) ||
                 (c == yenc_pkg::CH_LF)  || (c == yenc_pkg::CH_EQ);
    assign dot = (c == yenc_pkg::CH_DOT) && (line_count == 8'd0);

    // The count is taken in ten bits so that it cannot wrap before the compare.
    assign n_data  = (dot || esc) ? 2'd2 : 2'd1;
    assign cnt_sum = {2'b00, line_count} + {8'd0, n_data};
    assign brk     = cnt_sum >= {2'b00, line_length};
    assign crc_upd = yenc_pkg::crc32_byte(crc_in, data_byte);

    always_comb
    begin
        grp.chars = '0;
        case ({dot, esc})
            2'b10:
            begin
                grp.chars[0] = yenc_pkg::CH_DOT;
                grp.chars[1] = yenc_pkg::CH_DOT;
            end
            2'b01:
            begin
                grp.chars[0] = yenc_pkg::CH_EQ;
                grp.chars[1] = c + yenc_pkg::ESC_OFFSET;
            end
            default:
            begin
                grp.chars[0] = c;
            end
        endcase
        grp.num = {1'b0, n_data};
        if (brk)
        begin
            grp.chars[n_data]        = yenc_pkg::CH_CR;
            grp.chars[n_data + 2'd1] = yenc_pkg::CH_LF;
            grp.num                  = {1'b0, n_data} + 3'd2;
        end
        grp.last = last_byte;
        grp.crc  = last_byte ? ~crc_upd : 32'd0;
    end

    assign count_next = (brk || last_byte) ? 8'd0 : cnt_sum[7:0];
    assign crc_next   = last_byte ? yenc_pkg::CRC_INIT : crc_upd;

endmodule
`default_nettype wire

// ===== hdl/yenc_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yEnc output stage
// Holds one group of encoded characters and sends it one beat at a time.
// ----------------------------------------------------------------------------
module yenc_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire yenc_pkg::group_t grp_in,
    output logic                  free,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [39:0]           m_tdata,   // out_byte [7:0], crc_value [39:8]
    output logic                  m_tlast,   // run_end
    output logic                  m_tuser    // crc_valid
);

    yenc_pkg::group_t grp_reg;
    logic             valid_reg;
    logic [1:0]       idx_reg;
    logic             last_beat;

    assign last_beat = ({1'b0, idx_reg} + 3'd1) == grp_reg.num;
    assign free      = !valid_reg || (m_tready && last_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (valid_reg && m_tready)
        begin
            if (last_beat)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp_in;
        end
    end

    assign m_tvalid      = valid_reg;
    assign m_tdata[7:0]  = grp_reg.chars[idx_reg];
    assign m_tdata[39:8] = last_beat ? grp_reg.crc : 32'd0;
    assign m_tlast       = last_beat;
    assign m_tuser       = valid_reg && last_beat && grp_reg.last;

    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ({1'b0, idx_reg} < grp_reg.num))
        else $error("character index beyond its group");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("group loaded while the previous one is still being sent");

    a_crc_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tuser |-> (m_tvalid && m_tlast))
        else $error("CRC flagged on a beat that does not end its group");

    a_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[39:8] == 32'd0))
        else $error("CRC field not zero outside the end of a message");

endmodule
`default_nettype wire

// ===== hdl/yenc_line_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yEnc line encoder unit
// Encodes a raw byte stream to yEnc with NNTP dot-stuffing, CR LF line
// breaking at a configurable length and a running CRC-32 per message.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  -------  ---------  ---------------------------------------------------
//  s_*      in         tdata[7:0] data_byte, tlast last_byte
//  m_*      out        tdata[7:0] out_byte, tdata[39:8] crc_value,
//                      tlast run_end, tuser crc_valid
//  cfg_*    in         data[7:0] line_length (reset 128)
//
// Each raw byte yields one to four output beats on the master channel,
// and that beat count sets the rate.
// The whole encoding of a byte is done in the cycle it is accepted and
// loaded into the output stage, and the next byte is accepted in the same
// cycle as the last beat of the current group leaves, so groups follow
// with no gap. A stall on m_tready holds the current beat and, once the
// output stage is full, holds s_tready low. Reset clears the line count,
// sets the CRC register to all ones and the line length to 128.
// ----------------------------------------------------------------------------
module yenc_line_encoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte [7:0]
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_byte [7:0], crc_value [39:8]
    output logic             m_tlast,   // run_end
    output logic             m_tuser,   // crc_valid
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // line_length [7:0]
);

    logic [7:0]       line_length_reg;
    logic [7:0]       line_count_reg;
    logic [31:0]      crc_reg;
    logic [7:0]       line_count_next;
    logic [31:0]      crc_next;
    yenc_pkg::group_t grp;
    logic             accept;
    logic             free;

    // The configuration register can always be written.
    assign cfg_ready = 1'b1;
    assign s_tready  = free;
    assign accept    = s_tvalid && s_tready;

    yenc_enc_core u_core (
        .data_byte   (s_tdata),
        .last_byte   (s_tlast),
        .line_count  (line_count_reg),
        .line_length (line_length_reg),
        .crc_in      (crc_reg),
        .grp         (grp),
        .count_next  (line_count_next),
        .crc_next    (crc_next)
    );

    // Line and CRC state advance when a byte is accepted, so the following
    // byte is encoded against it straight away.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= yenc_pkg::LINE_LENGTH_RESET;
            line_count_reg  <= 8'd0;
            crc_reg         <= yenc_pkg::CRC_INIT;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                line_length_reg <= cfg_data;
            end
            if (accept)
            begin
                line_count_reg <= line_count_next;
                crc_reg        <= crc_next;
            end
        end
    end

    yenc_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .grp_in   (grp),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== verif/yenc_line_encoder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yEnc line encoder unit testbench
// Streams raw bytes into the encoder and checks every encoded output beat
// against an independent prediction. The prediction covers the escape rules,
// dot-stuffing, the line breaks and the per-message CRC-32. The line length
// is changed between phases, and both handshakes are stalled at random.
// ----------------------------------------------------------------------------
module yenc_line_encoder_unit_test;

    localparam int CLK_HIGH_NS   = 2;
    localparam int CLK_LOW_NS    = 2;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 200000;

    // One raw byte as the sender presents it.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } raw_item_t;

    // One encoded character as it should leave the master channel.
    typedef struct {
        logic [7:0]  out_byte;
        logic        run_end;
        logic [31:0] crc_value;
        logic        crc_valid;
    } enc_char_t;

    // Every input starts at a known value; reset is held from time zero.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;     // data_byte [7:0]
    logic        s_tlast   = 1'b0;   // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;            // out_byte [7:0], crc_value [39:8]
    logic        m_tlast;            // run_end
    logic        m_tuser;            // crc_valid
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;     // line_length [7:0]

    // Bytes waiting for the driver, and characters waiting for the DUT.
    raw_item_t   raw_bytes_pending[$];
    enc_char_t   expected_chars[$];

    // Prediction state: a private copy of the encoder's registers.
    logic [7:0]  line_len_model   = yenc_pkg::LINE_LENGTH_RESET;
    logic [7:0]  line_count_model = '0;
    logic [31:0] crc_model        = yenc_pkg::CRC_INIT;

    // Stall percentages used by the driver and by the ready generator.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    logic        in_beat_taken = 1'b0;
    raw_item_t   next_item;

    int unsigned error_count    = 0;
    int unsigned bytes_accepted = 0;
    int unsigned chars_checked  = 0;
    int unsigned messages_done  = 0;
    int unsigned line_breaks    = 0;
    int unsigned cycle_count    = 0;
    logic [7:0]  mid_length;

    yenc_line_encoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #CLK_LOW_NS  clk = 1'b1;
        #CLK_HIGH_NS clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Reflected CRC-32 step over one byte, one bit at a time with a mask
    // in place of the branch.
    function automatic logic [31:0] crc_after_byte(input logic [31:0] crc,
                                                   input logic [7:0]  raw);
        logic [31:0] acc;
        acc = crc ^ {24'd0, raw};
        for (int b = 0; b < 8; b++)
        begin
            acc = (acc >> 1) ^ (yenc_pkg::CRC_POLY & {32{acc[0]}});
        end
        return acc;
    endfunction

    function automatic enc_char_t plain_char(input logic [7:0] ch);
        enc_char_t r;
        r.out_byte  = ch;
        r.run_end   = 1'b0;
        r.crc_value = '0;
        r.crc_valid = 1'b0;
        return r;
    endfunction

    // Works out the group of characters that one accepted raw byte causes
    // and appends it to the expected characters, updating the model state.
    task automatic encode_byte(input raw_item_t item);
        logic [7:0]  shifted;
        logic [7:0]  escaped;
        int unsigned count;
        enc_char_t   group[$];
        shifted   = item.data_byte + yenc_pkg::CHAR_OFFSET;
        escaped   = shifted + yenc_pkg::ESC_OFFSET;
        crc_model = crc_after_byte(crc_model, item.data_byte);
        count     = line_count_model;
        // A dot that would open a line goes out twice.
        if (shifted == yenc_pkg::CH_DOT && count == 0)
        begin
            group.push_back(plain_char(yenc_pkg::CH_DOT));
            count++;
        end
        if (shifted inside {yenc_pkg::CH_NUL, yenc_pkg::CH_CR,
                            yenc_pkg::CH_LF, yenc_pkg::CH_EQ})
        begin
            group.push_back(plain_char(yenc_pkg::CH_EQ));
            group.push_back(plain_char(escaped));
            count += 2;
        end
        else
        begin
            group.push_back(plain_char(shifted));
            count++;
        end
        // The count is compared in a wide integer, so it never wraps.
        if (count >= line_len_model)
        begin
            group.push_back(plain_char(yenc_pkg::CH_CR));
            group.push_back(plain_char(yenc_pkg::CH_LF));
            count = 0;
            line_breaks++;
        end
        line_count_model = count[7:0];
        group[group.size() - 1].run_end = 1'b1;
        if (item.last_byte)
        begin
            group[group.size() - 1].crc_value = ~crc_model;
            group[group.size() - 1].crc_valid = 1'b1;
            crc_model        = yenc_pkg::CRC_INIT;
            line_count_model = '0;
            messages_done++;
        end
        foreach (group[i])
        begin
            expected_chars.push_back(group[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch at character %0d: %s got %h, expected %h",
                 $realtime, chars_checked, what, got, want);
        error_count++;
    endtask

    task automatic check_char();
        enc_char_t want;
        if (expected_chars.size() == 0)
        begin
            report_mismatch("unexpected beat, out_byte", {24'd0, m_tdata[7:0]}, '0);
        end
        else
        begin
            want = expected_chars.pop_front();
            if (m_tdata[7:0] !== want.out_byte)
            begin
                report_mismatch("out_byte", {24'd0, m_tdata[7:0]}, {24'd0, want.out_byte});
            end
            if (m_tlast !== want.run_end)
            begin
                report_mismatch("run_end", {31'd0, m_tlast}, {31'd0, want.run_end});
            end
            if (m_tdata[39:8] !== want.crc_value)
            begin
                report_mismatch("crc_value", m_tdata[39:8], want.crc_value);
            end
            if (m_tuser !== want.crc_valid)
            begin
                report_mismatch("crc_valid", {31'd0, m_tuser}, {31'd0, want.crc_valid});
            end
        end
        chars_checked++;
    endtask

    // Monitor: every handshake is sampled at the rising edge. A raw byte is
    // predicted before the output beat of the same edge is checked; the
    // output stage is registered, so the two never belong together anyway.
    always @(posedge clk)
    begin
        in_beat_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                line_len_model = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                encode_byte('{data_byte: s_tdata, last_byte: s_tlast});
                bytes_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                check_char();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving, on the falling edge
    // ------------------------------------------------------------------------

    // The sender keeps a beat steady until it has been taken, then either
    // offers the next pending byte or idles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_beat_taken)
            begin
                if (raw_bytes_pending.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = raw_bytes_pending.pop_front();
                    s_tdata  <= next_item.data_byte;
                    s_tlast  <= next_item.last_byte;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The run is cut short if the encoder stops making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters still expected",
                     cycle_count, expected_chars.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Picks a raw byte; in special_pct cases of a hundred it is one that
    // lands on a character needing an escape or on a dot.
    function automatic logic [7:0] pick_raw(input int unsigned special_pct);
        logic [7:0] r;
        if ($urandom_range(99) < special_pct)
        begin
            case ($urandom_range(4))
                0:       r = yenc_pkg::CH_NUL - yenc_pkg::CHAR_OFFSET;
                1:       r = yenc_pkg::CH_CR  - yenc_pkg::CHAR_OFFSET;
                2:       r = yenc_pkg::CH_LF  - yenc_pkg::CHAR_OFFSET;
                3:       r = yenc_pkg::CH_EQ  - yenc_pkg::CHAR_OFFSET;
                default: r = yenc_pkg::CH_DOT - yenc_pkg::CHAR_OFFSET;
            endcase
        end
        else
        begin
            r = $urandom_range(255);
        end
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] raw, input logic last);
        raw_bytes_pending.push_back('{data_byte: raw, last_byte: last});
    endtask

    // Queues whole messages of random length with random content until
    // exactly n_bytes have been queued; the final message is cut to fit.
    task automatic queue_messages(input int unsigned n_bytes,
                                  input int unsigned max_len,
                                  input int unsigned special_pct);
        int unsigned left;
        int unsigned len;
        left = n_bytes;
        while (left != 0)
        begin
            len = $urandom_range(max_len, 1);
            if (len > left)
            begin
                len = left;
            end
            for (int i = 0; i < len; i++)
            begin
                queue_byte(pick_raw(special_pct), (i == len - 1));
            end
            left -= len;
        end
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Waits until every queued byte has gone in and every character out.
    task automatic wait_for_idle();
        while (raw_bytes_pending.size() != 0 || s_tvalid ||
               expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Line length writes happen only with the encoder drained.
    task automatic write_line_length(input logic [7:0] len);
        wait_for_idle();
        @(negedge clk);
        cfg_data  <= len;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // First pattern: the sender idles a third of the time, the
        // receiver well over half.
        set_idling(34, 61);

        // Directed bytes at the reset line length of 128. The first byte
        // maps to a dot on an empty line and must be stuffed, the second
        // must not. Then each escaped character, the field extremes, a
        // one-byte message that opens with a dot, and escaped last bytes.
        queue_byte(yenc_pkg::CH_DOT - yenc_pkg::CHAR_OFFSET, 1'b0);
        queue_byte(yenc_pkg::CH_DOT - yenc_pkg::CHAR_OFFSET, 1'b0);
        queue_byte(yenc_pkg::CH_NUL - yenc_pkg::CHAR_OFFSET, 1'b0);
        queue_byte(yenc_pkg::CH_CR  - yenc_pkg::CHAR_OFFSET, 1'b0);
        queue_byte(yenc_pkg::CH_LF  - yenc_pkg::CHAR_OFFSET, 1'b0);
        queue_byte(yenc_pkg::CH_EQ  - yenc_pkg::CHAR_OFFSET, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b1);
        queue_byte(yenc_pkg::CH_DOT - yenc_pkg::CHAR_OFFSET, 1'b1);
        queue_byte(yenc_pkg::CH_NUL - yenc_pkg::CHAR_OFFSET, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h02, 1'b0);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'hFD, 1'b0);
        queue_byte(yenc_pkg::CH_EQ  - yenc_pkg::CHAR_OFFSET, 1'b1);

        // Shortest legal line: every character ends a line, and an escape
        // overshoots the limit by one.
        write_line_length(8'd1);
        queue_messages(40, 12, 40);

        // Longest line, filled mainly with escapes so that it breaks.
        write_line_length(8'd255);
        queue_messages(130, 200, 90);

        // Second pattern: the sender stalls more than the receiver.
        write_line_length(8'd0);
        set_idling(61, 34);
        // Out-of-range zero length: a break after every byte, and every
        // dot stuffed because each character starts a line.
        queue_messages(25, 8, 50);

        write_line_length(8'd2);
        queue_messages(40, 16, 30);

        mid_length = $urandom_range(254, 3);
        write_line_length(mid_length);
        queue_messages(50, 40, 25);

        // Last pattern: no stalls at all, groups back to back.
        write_line_length(8'd3);
        set_idling(0, 0);
        queue_messages(40, 20, 30);

        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_chars.size() != 0)
        begin
            report_mismatch("characters never seen", expected_chars.size(), '0);
        end

        $display("Encoded %0d raw bytes in %0d messages, %0d characters checked, %0d line breaks.",
                 bytes_accepted, messages_done, chars_checked, line_breaks);
        $display("Line lengths 128, 1, 255, 0, 2, %0d and 3 under three stall patterns.",
                 mid_length);
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
